// ===== sv/rrpg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow ring pixel generator package
// Shared constants, types, hue scaling helpers and the microcode program.
// ----------------------------------------------------------------------------
package rrpg_pkg;

  // Ring and hue resolution.
  localparam int unsigned LED_COUNT  = 8;
  localparam int unsigned HUE_BITS   = 16;
  localparam int unsigned RUN_LEN    = (LED_COUNT > 64) ? 64 : LED_COUNT;
  localparam int unsigned UP_SHIFT   = (HUE_BITS >= 16) ? (HUE_BITS - 16) : 0;
  localparam int unsigned DOWN_SHIFT = (HUE_BITS >= 16) ? 0 : (16 - HUE_BITS);

  // Field and datapath widths.
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned W_W    = HUE_BITS + 1;
  localparam int unsigned PROD_W = 16 + W_W;
  localparam int unsigned SUM_W  = HUE_BITS + 18;

  localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(RUN_LEN - 1);
  localparam logic [W_W-1:0]   FULL_TURN  = W_W'(1) << HUE_BITS;
  localparam logic [SUM_W-1:0] ROUND_TERM = SUM_W'(255) << HUE_BITS;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SATURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_ADV    = 2'd3;

  typedef struct packed {
    logic [7:0]  brightness;
    logic [7:0]  saturation;
    logic [15:0] hue_step_per_led;
    logic [15:0] hue_advance_per_tick;
  } cfg_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD_AB,
    OP_W_FULL,
    OP_W_ZERO,
    OP_W_HUE,
    OP_MUL,
    OP_SUM,
    OP_RECIP,
    OP_CORR,
    OP_EMIT,
    OP_NEXT,
    OP_ADVANCE
  } op_e;

  // Destination of a finished channel value.
  typedef enum logic [1:0] {
    DST_CC,
    DST_ZZ,
    DST_XX
  } dst_e;

  // Jump conditions: the jump is taken when the condition holds.
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_OUT_BUSY,
    C_MORE
  } cond_e;

  localparam int unsigned STEP_W   = 5;
  localparam int unsigned PROG_LEN = 20;

  // Program labels.
  localparam logic [STEP_W-1:0] S_WAIT = 5'd0;
  localparam logic [STEP_W-1:0] S_PIX  = 5'd12;
  localparam logic [STEP_W-1:0] S_EMIT = 5'd17;

  typedef struct packed {
    logic              in_rdy;
    op_e               op;
    dst_e              dst;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    dst_e dst;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
    logic more_pix;
  } status_t;

  function automatic uword_t mk_uw(logic rdy, op_e op, dst_e dst, cond_e cond,
                                   logic [STEP_W-1:0] target);
    uword_t w;
    w.in_rdy = rdy;
    w.op     = op;
    w.dst    = dst;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Microcode program. Each channel value takes five steps: weight load,
  // multiply, sum with rounding, reciprocal estimate and correction.
  function automatic uword_t ucode_rom(logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      5'd0:    w = mk_uw(1'b1, OP_ACCEPT,  DST_CC, C_NO_IN,    S_WAIT);
      5'd1:    w = mk_uw(1'b0, OP_LOAD_AB, DST_CC, C_NEXT,     S_WAIT);
      5'd2:    w = mk_uw(1'b0, OP_W_FULL,  DST_CC, C_NEXT,     S_WAIT);
      5'd3:    w = mk_uw(1'b0, OP_MUL,     DST_CC, C_NEXT,     S_WAIT);
      5'd4:    w = mk_uw(1'b0, OP_SUM,     DST_CC, C_NEXT,     S_WAIT);
      5'd5:    w = mk_uw(1'b0, OP_RECIP,   DST_CC, C_NEXT,     S_WAIT);
      5'd6:    w = mk_uw(1'b0, OP_CORR,    DST_CC, C_NEXT,     S_WAIT);
      5'd7:    w = mk_uw(1'b0, OP_W_ZERO,  DST_ZZ, C_NEXT,     S_WAIT);
      5'd8:    w = mk_uw(1'b0, OP_MUL,     DST_ZZ, C_NEXT,     S_WAIT);
      5'd9:    w = mk_uw(1'b0, OP_SUM,     DST_ZZ, C_NEXT,     S_WAIT);
      5'd10:   w = mk_uw(1'b0, OP_RECIP,   DST_ZZ, C_NEXT,     S_WAIT);
      5'd11:   w = mk_uw(1'b0, OP_CORR,    DST_ZZ, C_NEXT,     S_WAIT);
      5'd12:   w = mk_uw(1'b0, OP_W_HUE,   DST_XX, C_NEXT,     S_WAIT);
      5'd13:   w = mk_uw(1'b0, OP_MUL,     DST_XX, C_NEXT,     S_WAIT);
      5'd14:   w = mk_uw(1'b0, OP_SUM,     DST_XX, C_NEXT,     S_WAIT);
      5'd15:   w = mk_uw(1'b0, OP_RECIP,   DST_XX, C_NEXT,     S_WAIT);
      5'd16:   w = mk_uw(1'b0, OP_CORR,    DST_XX, C_NEXT,     S_WAIT);
      5'd17:   w = mk_uw(1'b0, OP_EMIT,    DST_XX, C_OUT_BUSY, S_EMIT);
      5'd18:   w = mk_uw(1'b0, OP_NEXT,    DST_XX, C_MORE,     S_PIX);
      5'd19:   w = mk_uw(1'b0, OP_ADVANCE, DST_CC, C_ALWAYS,   S_WAIT);
      default: w = mk_uw(1'b0, OP_NOP,     DST_CC, C_ALWAYS,   S_WAIT);
    endcase
    return w;
  endfunction

  // Scale an unsigned 16-bit turn fraction to HUE_BITS bits.
  function automatic logic [HUE_BITS-1:0] scale_u16(logic [15:0] v);
    logic [39:0] x;
    x = 40'(v);
    x = x << UP_SHIFT;
    x = x >> DOWN_SHIFT;
    return x[HUE_BITS-1:0];
  endfunction

  // Scale a signed 16-bit turn fraction to HUE_BITS bits.
  function automatic logic [HUE_BITS-1:0] scale_s16(logic [15:0] v);
    logic signed [39:0] x;
    x = 40'(signed'(v));
    x = x <<< UP_SHIFT;
    x = x >>> DOWN_SHIFT;
    return x[HUE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/rrpg_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow ring configuration registers
// Write-only register file for brightness, saturation and hue steps.
// ----------------------------------------------------------------------------
module rrpg_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rrpg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i,
  output rrpg_pkg::cfg_t                      cfg_o
);
  import rrpg_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index of a write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BRIGHTNESS: cfg_d.brightness           = cfg_data_i[7:0];
        CFG_SATURATION: cfg_d.saturation           = cfg_data_i[7:0];
        CFG_HUE_STEP:   cfg_d.hue_step_per_led     = cfg_data_i;
        CFG_HUE_ADV:    cfg_d.hue_advance_per_tick = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brightness           <= 8'd51;
      cfg_q.saturation           <= 8'd255;
      cfg_q.hue_step_per_led     <= 16'd8192;
      cfg_q.hue_advance_per_tick <= 16'd437;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== sv/rrpg_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow ring microcode sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
module rrpg_sequencer (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire rrpg_pkg::status_t status_i,
  output rrpg_pkg::ctrl_t        ctrl_o,
  output wire logic              in_ready_o
);
  import rrpg_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  uword_t            uw;
  logic              take;

  // Fetch the control word and evaluate its jump condition.
  always_comb begin
    uw = ucode_rom(step_q);
    case (uw.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = !in_valid_i;
      C_OUT_BUSY: take = status_i.out_busy;
      C_MORE:     take = status_i.more_pix;
      default:    take = 1'b1;
    endcase
    step_d = take ? uw.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o.op  = uw.op;
  assign ctrl_o.dst = uw.dst;
  assign in_ready_o = uw.in_rdy;

`ifndef SYNTHESIS
  // The step counter stays inside the program.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < STEP_W'(PROG_LEN))
    else $error("step counter left the program");

  // An accepted word starts the setup steps.
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> step_q == S_WAIT + STEP_W'(1))
    else $error("accept did not start the run");
`endif

endmodule
`default_nettype wire

// ===== sv/rrpg_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rainbow ring datapath
// Hue accumulator, one shared multiplier with divide-by-255 logic, and the
// output word register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
module rrpg_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rrpg_pkg::cfg_t             cfg_i,
  input  wire rrpg_pkg::ctrl_t            ctrl_i,
  output rrpg_pkg::status_t               status_o,
  input  wire logic                       in_valid_i,
  input  wire logic                       restart_phase_i,
  input  wire logic                       out_ready_i,
  output wire logic                       out_valid_o,
  output wire logic [rrpg_pkg::IDX_W-1:0] pixel_index_o,
  output wire logic [7:0]                 red_o,
  output wire logic [7:0]                 green_o,
  output wire logic [7:0]                 blue_o,
  output wire logic                       last_pixel_o
);
  import rrpg_pkg::*;

  // Control registers.
  logic [HUE_BITS-1:0] base_hue_q, base_hue_d;
  logic [HUE_BITS-1:0] hue_q, hue_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                out_valid_q, out_valid_d;

  // Payload registers.
  logic [15:0]       a_q, b_q;
  logic [W_W-1:0]    w_q;
  logic [2:0]        sector_q;
  logic [PROD_W-1:0] prod_q;
  logic [15:0]       y_q;
  logic [7:0]        est_q;
  logic [7:0]        cc_q, zz_q, xx_q;
  logic [IDX_W-1:0]  pix_q;
  logic [7:0]        red_q, green_q, blue_q;
  logic              last_q;

  logic                is_last, emit_load;
  logic [HUE_BITS+2:0] hue6;
  logic [HUE_BITS-1:0] frac;
  logic [W_W-1:0]      w_hue;
  logic [SUM_W-1:0]    sum_n;
  logic [23:0]         y257;
  logic [15:0]         corr_r;
  logic [7:0]          chan_rnd;
  logic [7:0]          r_sel, g_sel, b_sel;

  assign is_last   = (idx_q == LAST_IDX);
  assign emit_load = (ctrl_i.op == OP_EMIT) && !(out_valid_q && !out_ready_i);

  assign status_o.out_busy = out_valid_q && !out_ready_i;
  assign status_o.more_pix = !is_last;

  // Sector and weight of the current hue: 6*h splits into sector and fraction.
  always_comb begin
    hue6  = {2'b00, hue_q, 1'b0} + {1'b0, hue_q, 2'b00};
    frac  = hue6[HUE_BITS-1:0];
    w_hue = hue6[HUE_BITS] ? (FULL_TURN - W_W'(frac)) : W_W'(frac);
  end

  // Numerator over 2^(HUE_BITS+1): 2*A*F + 2*B*w + 255*F, then halved.
  always_comb begin
    sum_n = SUM_W'({a_q, {(HUE_BITS + 1){1'b0}}}) + SUM_W'({prod_q, 1'b0}) + ROUND_TERM;
  end

  // Divide by 255: estimate with 257/65536, which is low by at most one.
  always_comb begin
    y257     = {8'b0, y_q} + {y_q, 8'b0};
    corr_r   = y_q - ({est_q, 8'b0} - {8'b0, est_q});
    chan_rnd = (corr_r >= 16'd255) ? est_q + 8'd1 : est_q;
  end

  // Place C, X and zero channels by sector.
  always_comb begin
    case (sector_q)
      3'd0: begin r_sel = cc_q; g_sel = xx_q; b_sel = zz_q; end
      3'd1: begin r_sel = xx_q; g_sel = cc_q; b_sel = zz_q; end
      3'd2: begin r_sel = zz_q; g_sel = cc_q; b_sel = xx_q; end
      3'd3: begin r_sel = zz_q; g_sel = xx_q; b_sel = cc_q; end
      3'd4: begin r_sel = xx_q; g_sel = zz_q; b_sel = cc_q; end
      default: begin r_sel = cc_q; g_sel = zz_q; b_sel = xx_q; end
    endcase
  end

  // Next values of the control registers.
  always_comb begin
    base_hue_d  = base_hue_q;
    hue_d       = hue_q;
    idx_d       = idx_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    case (ctrl_i.op)
      OP_ACCEPT: begin
        if (in_valid_i) begin
          base_hue_d = restart_phase_i ? '0 : base_hue_q;
          hue_d      = restart_phase_i ? '0 : base_hue_q;
          idx_d      = '0;
        end
      end
      OP_EMIT: begin
        if (emit_load) begin
          out_valid_d = 1'b1;
        end
      end
      OP_NEXT: begin
        if (!is_last) begin
          hue_d = hue_q + scale_u16(cfg_i.hue_step_per_led);
          idx_d = idx_q + IDX_W'(1);
        end
      end
      OP_ADVANCE: begin
        base_hue_d = base_hue_q + scale_s16(cfg_i.hue_advance_per_tick);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_hue_q  <= '0;
      hue_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_hue_q  <= base_hue_d;
      hue_q       <= hue_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Arithmetic and output registers.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      OP_LOAD_AB: begin
        a_q <= 16'(cfg_i.brightness) * 16'(8'd255 - cfg_i.saturation);
        b_q <= 16'(cfg_i.brightness) * 16'(cfg_i.saturation);
      end
      OP_W_FULL: w_q <= FULL_TURN;
      OP_W_ZERO: w_q <= '0;
      OP_W_HUE: begin
        w_q      <= w_hue;
        sector_q <= hue6[HUE_BITS+2:HUE_BITS];
      end
      OP_MUL:   prod_q <= PROD_W'(b_q) * PROD_W'(w_q);
      OP_SUM:   y_q    <= sum_n[HUE_BITS+16:HUE_BITS+1];
      OP_RECIP: est_q  <= y257[23:16];
      OP_CORR: begin
        case (ctrl_i.dst)
          DST_CC:  cc_q <= chan_rnd;
          DST_ZZ:  zz_q <= chan_rnd;
          default: xx_q <= chan_rnd;
        endcase
      end
      OP_EMIT: begin
        if (emit_load) begin
          pix_q   <= idx_q;
          red_q   <= r_sel;
          green_q <= g_sel;
          blue_q  <= b_sel;
          last_q  <= is_last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pix_q;
  assign red_o         = red_q;
  assign green_o       = green_q;
  assign blue_o        = blue_q;
  assign last_pixel_o  = last_q;

`ifndef SYNTHESIS
  // The reciprocal estimate is never more than one below the quotient.
  a_corr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_CORR) |-> corr_r < 16'd510)
    else $error("divide-by-255 estimate out of range");

  // No channel is brighter than the configured brightness.
  a_chan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_EMIT && emit_load) |=>
      (red_q <= cfg_i.brightness && green_q <= cfg_i.brightness &&
       blue_q <= cfg_i.brightness))
    else $error("channel exceeds brightness");

  // The end-of-run mark sits on the last ring position only.
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> pix_q == LAST_IDX)
    else $error("last pixel flag on wrong index");
`endif

endmodule
`default_nettype wire

// ===== sv/rotating_rainbow_pixel_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotating rainbow pixel generator
// Each input word is one animation tick and yields one RGB word per LED of
// the ring. A new word is taken only after the previous tick's ring run and
// base hue advance are done. A microcoded sequencer steps one shared
// multiplier and a divide-by-255 stage: one step to accept, one for the
// brightness products, five per channel value (weight load, multiply, sum,
// reciprocal estimate and correction) for the full and zero weight values
// once per tick and for the hue weight of each LED, one step per LED to emit
// and one to step the hue, and a final step to advance the base hue. A
// stalled output holds the program at its emit step. Configuration must be
// written only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rotating_rainbow_pixel_generator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [rrpg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i,
  input  wire logic                           in_valid_i,
  output wire logic                           in_ready_o,
  input  wire logic                           restart_phase_i,
  output wire logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  output wire logic [rrpg_pkg::IDX_W-1:0]     pixel_index_o,
  output wire logic [7:0]                     red_o,
  output wire logic [7:0]                     green_o,
  output wire logic [7:0]                     blue_o,
  output wire logic                           last_pixel_o
);
  import rrpg_pkg::*;

  cfg_t    cfg;
  ctrl_t   ctrl;
  status_t status;

  // Configuration registers.
  rrpg_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Control program.
  rrpg_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  // Arithmetic and output word.
  rrpg_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .in_valid_i      (in_valid_i),
    .restart_phase_i (restart_phase_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .pixel_index_o   (pixel_index_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .last_pixel_o    (last_pixel_o)
  );

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating rainbow pixel generator testbench
// Sends animation ticks and checks every RGB word of each ring run against a
// fixed-point HSV prediction kept in a scoreboard. The run covers register
// extremes, hue wrap, negative advance and zero saturation, then random ticks
// under several configurations and idle patterns, including one long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------

// One RGB word as it leaves the block.
typedef struct packed {
  logic [rrpg_pkg::IDX_W-1:0] index;
  logic [7:0]                 red;
  logic [7:0]                 green;
  logic [7:0]                 blue;
  logic                       last;
} pixel_word_t;

// The six sectors of the color wheel, in hue order.
typedef enum int {
  SEC_RED_YELLOW,
  SEC_YELLOW_GREEN,
  SEC_GREEN_CYAN,
  SEC_CYAN_BLUE,
  SEC_BLUE_MAGENTA,
  SEC_MAGENTA_RED
} hue_sector_e;

class pixel_scoreboard;
  bit [7:0]          brightness;
  bit [7:0]          saturation;
  bit [15:0]         hue_step;
  bit [15:0]         hue_advance;
  longint unsigned   base_hue;
  pixel_word_t       expected_pixels[$];
  int                errors;

  function new();
    brightness  = 8'd51;
    saturation  = 8'd255;
    hue_step    = 16'd8192;
    hue_advance = 16'd437;
    base_hue    = 0;
    errors      = 0;
  endfunction

  // Mirror one register write.
  function void write_reg(logic [rrpg_pkg::CFG_IDX_W-1:0] index, logic [15:0] data);
    case (index)
      rrpg_pkg::CFG_BRIGHTNESS: brightness  = data[7:0];
      rrpg_pkg::CFG_SATURATION: saturation  = data[7:0];
      rrpg_pkg::CFG_HUE_STEP:   hue_step    = data;
      rrpg_pkg::CFG_HUE_ADV:    hue_advance = data;
      default: ;
    endcase
  endfunction

  // Channel level for a given weight, rounded to nearest with ties up.
  function logic [7:0] channel_level(longint unsigned weight);
    longint unsigned v, s, full, num, den;
    v    = brightness;
    s    = saturation;
    full = 64'd1 << rrpg_pkg::HUE_BITS;
    num  = v * (255 - s) * full + v * s * weight;
    den  = 255 * full;
    return 8'((2 * num + den) / (2 * den));
  endfunction

  // Expected words of one tick's ring run, then the base hue update.
  function void predict_ring(logic restart);
    longint unsigned mask, full, step, hue, t, f, weight;
    longint          adv;
    int              sector;
    logic [7:0]      cc, xx, zz;
    pixel_word_t     px;
    mask = (64'd1 << rrpg_pkg::HUE_BITS) - 1;
    full = mask + 1;
    step = hue_step;
    step = ((step << rrpg_pkg::UP_SHIFT) >> rrpg_pkg::DOWN_SHIFT) & mask;
    adv  = $signed(hue_advance);
    adv  = (adv <<< rrpg_pkg::UP_SHIFT) >>> rrpg_pkg::DOWN_SHIFT;
    if (restart) begin
      base_hue = 0;
    end
    for (int i = 0; i < rrpg_pkg::RUN_LEN; i++) begin
      hue    = (base_hue + longint'(i) * step) & mask;
      t      = hue * 6;
      sector = int'(t >> rrpg_pkg::HUE_BITS);
      f      = t & mask;
      // Odd sectors fall from full weight, even sectors rise from zero.
      weight = sector[0] ? full - f : f;
      cc     = channel_level(full);
      zz     = channel_level(0);
      xx     = channel_level(weight);
      case (hue_sector_e'(sector))
        SEC_RED_YELLOW:   begin px.red = cc; px.green = xx; px.blue = zz; end
        SEC_YELLOW_GREEN: begin px.red = xx; px.green = cc; px.blue = zz; end
        SEC_GREEN_CYAN:   begin px.red = zz; px.green = cc; px.blue = xx; end
        SEC_CYAN_BLUE:    begin px.red = zz; px.green = xx; px.blue = cc; end
        SEC_BLUE_MAGENTA: begin px.red = xx; px.green = zz; px.blue = cc; end
        default:          begin px.red = cc; px.green = zz; px.blue = xx; end
      endcase
      px.index = rrpg_pkg::IDX_W'(i);
      px.last  = (i == rrpg_pkg::RUN_LEN - 1);
      expected_pixels.push_back(px);
    end
    base_hue = (base_hue + adv) & mask;
  endfunction

  function void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  // Compare one output word with the oldest expected word.
  function void check_pixel(pixel_word_t got);
    pixel_word_t want;
    if (expected_pixels.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual index %0d rgb %0d %0d %0d",
               $time, got.index, got.red, got.green, got.blue);
      errors++;
      return;
    end
    want = expected_pixels.pop_front();
    compare_field("pixel_index", want.index, got.index);
    compare_field("red", want.red, got.red);
    compare_field("green", want.green, got.green);
    compare_field("blue", want.blue, got.blue);
    compare_field("last_pixel", want.last, got.last);
  endfunction

  function void check_drained();
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_pixels.size());
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 30;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           cfg_we_i        = 1'b0;
  logic [rrpg_pkg::CFG_IDX_W-1:0] cfg_index_i     = rrpg_pkg::CFG_BRIGHTNESS;
  logic [15:0]                    cfg_data_i      = 16'd0;
  logic                           in_valid_i      = 1'b0;
  logic                           restart_phase_i = 1'b0;
  logic                           out_ready_i     = 1'b0;
  logic                           in_ready_o;
  logic                           out_valid_o;
  logic [rrpg_pkg::IDX_W-1:0]     pixel_index_o;
  logic [7:0]                     red_o;
  logic [7:0]                     green_o;
  logic [7:0]                     blue_o;
  logic                           last_pixel_o;

  int     send_idle_pct    = 0;
  int     recv_stall_pct   = 0;
  int     holdoff_requests = 0;
  int     holdoff_served   = 0;
  int     holdoff_left     = 0;
  longint cycles           = 0;

  pixel_scoreboard ring_board = new();

  rotating_rainbow_pixel_generator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .restart_phase_i (restart_phase_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_index_o   (pixel_index_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .last_pixel_o    (last_pixel_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i  <= 1'b0;
      holdoff_left <= 0;
    end else if (holdoff_left > 0) begin
      out_ready_i  <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_requests) begin
      out_ready_i    <= 1'b0;
      holdoff_served <= holdoff_requests;
      holdoff_left   <= HOLDOFF_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every word the block hands over.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      ring_board.check_pixel(pixel_word_t'{pixel_index_o, red_o, green_o, blue_o,
                                           last_pixel_o});
    end
  end

  // Offer one tick, possibly after a random gap, and hold it until taken.
  task automatic send_tick(input logic restart);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i      <= 1'b0;
      restart_phase_i <= 1'($urandom);
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i      <= 1'b1;
    restart_phase_i <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    ring_board.predict_ring(restart);
  endtask

  // Wait until every expected word is out and the block has gone idle.
  task automatic drain_ring();
    in_valid_i <= 1'b0;
    while (ring_board.expected_pixels.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [rrpg_pkg::CFG_IDX_W-1:0] index,
                           input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    ring_board.write_reg(index, data);
  endtask

  // Write all four registers; the 8-bit ones get junk in the upper byte.
  task automatic apply_config(input logic [7:0] level, input logic [7:0] sat,
                              input logic [15:0] step, input logic [15:0] advance);
    write_cfg(rrpg_pkg::CFG_BRIGHTNESS, {8'($urandom), level});
    write_cfg(rrpg_pkg::CFG_SATURATION, {8'($urandom), sat});
    write_cfg(rrpg_pkg::CFG_HUE_STEP, step);
    write_cfg(rrpg_pkg::CFG_HUE_ADV, advance);
    cfg_we_i <= 1'b0;
  endtask

  // Random settings that land on the extremes fairly often.
  task automatic random_config();
    logic [7:0]  level, sat;
    logic [15:0] step, advance;
    case ($urandom_range(3))
      0:       level = 8'd0;
      1:       level = 8'd255;
      default: level = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0:       sat = 8'd0;
      1:       sat = 8'd255;
      default: sat = 8'($urandom);
    endcase
    case ($urandom_range(4))
      0:       step = 16'd0;
      1:       step = 16'hFFFF;
      2:       step = 16'($urandom_range(2000));
      default: step = 16'($urandom);
    endcase
    case ($urandom_range(4))
      0:       advance = 16'h8000;
      1:       advance = 16'h7FFF;
      2:       advance = 16'($urandom_range(4000) - 2000);
      default: advance = 16'($urandom);
    endcase
    apply_config(level, sat, step, advance);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: restart, then free-running rotation.
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_ring();

    // Full brightness and saturation, largest hue step (a step of minus one
    // per LED after wrapping), largest negative advance.
    apply_config(8'd255, 8'd255, 16'hFFFF, 16'h8000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_ring();

    // Dark ring with the largest positive advance.
    apply_config(8'd0, 8'd255, 16'd0, 16'h7FFF);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_ring();

    // Zero saturation: every channel equals brightness.
    apply_config(8'd255, 8'd0, 16'd10923, 16'hFFFF);
    send_tick(1'b0);
    send_tick(1'b1);
    drain_ring();

    // Tiny hue step, frozen rotation.
    apply_config(8'd200, 8'd128, 16'd1, 16'd0);
    send_tick(1'b0);
    send_tick(1'b0);
    drain_ring();

    // Sector boundaries with a small backward drift.
    apply_config(8'd128, 8'd200, 16'd10922, 16'hFE00);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_ring();

    // Random ticks under four idle patterns and several settings each.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int batch = 0; batch < 4; batch++) begin
        drain_ring();
        random_config();
        // Back up the block once while the sender keeps offering ticks.
        if (mode == 0 && batch == 0) begin
          holdoff_requests++;
        end
        for (int n = 0; n < 16; n++) begin
          send_tick($urandom_range(3) == 0);
        end
      end
    end

    drain_ring();
    ring_board.check_drained();
    if (ring_board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== rotating_rainbow_pixel_generator.f =====
sv/rrpg_pkg.sv
sv/rrpg_cfg_regs.sv
sv/rrpg_sequencer.sv
sv/rrpg_datapath.sv
sv/rotating_rainbow_pixel_generator.sv
tb/sv/testbench.sv
